[sv/bf3_pkg.sv]
`default_nettype none

package bf3_pkg;

	localparam int DEF_MAX_WIDTH    = 2048;
	localparam int DEF_MAX_CHANNELS = 3;
	localparam int IO_CHANNELS      = 3;

	localparam int WIDTH_W    = 12;
	localparam int HEIGHT_W   = 13;
	localparam int CHAN_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int ROW_W      = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

	localparam logic [WIDTH_W-1:0]  RST_IMAGE_WIDTH   = 12'd640;
	localparam logic [HEIGHT_W-1:0] RST_IMAGE_HEIGHT  = 13'd480;
	localparam logic [CHAN_W-1:0]   RST_CHANNEL_COUNT = 2'd3;

	localparam logic [ROW_W-1:0] ROW_LIMIT = 16'hFFFF;

	// floor(x/9) == (x * 3641) >> 15 for every nine-sample sum (x < 2296)
	localparam int SUM_W       = 12;
	localparam int PROD_W      = 24;
	localparam int RECIP_SHIFT = 15;
	localparam logic [SUM_W-1:0] RECIP_NINE = 12'd3641;

	typedef struct packed {
		logic top;
		logic bot;
		logic left;
		logic right;
	} rep_t;

	typedef struct packed {
		logic                   res;
		logic                   last;
		rep_t                   rep;
		logic [IO_CHANNELS-1:0] mask;
	} item_ctl_t;

endpackage

`default_nettype wire

[sv/bf3_ram.sv]
`default_nettype none

module bf3_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read-first: a same-cycle write is not seen
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[sv/bf3_lane.sv]
`default_nettype none

module bf3_lane (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          shift_en,
	input  wire logic          sum_en,
	input  wire logic [7:0]    col_top,
	input  wire logic [7:0]    col_mid,
	input  wire logic [7:0]    col_bot,
	input  wire bf3_pkg::rep_t rep,
	output logic      [7:0]    quo
);
	import bf3_pkg::*;

	logic [2:0][2:0][7:0] win_q;
	logic [2:0][7:0]      col_new;
	logic [2:0][1:0]      rsel;
	logic [2:0][1:0]      csel;
	logic [SUM_W-1:0]     sum;
	logic [SUM_W-1:0]     sum_s3;
	logic [PROD_W-1:0]    prod;

	assign col_new = {col_bot, col_mid, col_top};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (shift_en) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
				win_q[r][2] <= col_new[r];
			end
		end
	end

	always_comb begin
		rsel[0] = rep.top   ? 2'd1 : 2'd0;
		rsel[1] = 2'd1;
		rsel[2] = rep.bot   ? 2'd1 : 2'd2;
		csel[0] = rep.left  ? 2'd1 : 2'd0;
		csel[1] = 2'd1;
		csel[2] = rep.right ? 2'd1 : 2'd2;
		sum = '0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				sum = sum + SUM_W'(win_q[rsel[r]][csel[c]]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sum_en) begin
			sum_s3 <= sum;
		end
	end

	assign prod = PROD_W'(sum_s3) * PROD_W'(RECIP_NINE);
	assign quo  = prod[RECIP_SHIFT+7:RECIP_SHIFT];

endmodule

`default_nettype wire

[sv/box_filter_3x3_replicated_border_top.sv]
// channel  signals                                    direction
// cfg      cfg_valid/cfg_ready, cfg_index, cfg_data   into block
// req      req_valid/req_stall, req_type, chanN_in    into block
// rsp      rsp_valid/rsp_stall, chanN_out, frame_last out of block
//
// One item per clock unless held. A result reaches the output register via
// the stage-1, window and sum registers after the item completing its window;
// results trail the input by image_width+1 items, drained by image_width+1
// flush items. Both line buffers share one registered-read RAM; the whole
// pipeline holds while rsp is stalled with a result waiting. Reset clears
// counters and valid flags; line buffers stay undefined, needing no clearing.
`default_nettype none

module box_filter_3x3_replicated_border_top #(
	parameter int MAX_WIDTH    = bf3_pkg::DEF_MAX_WIDTH,
	parameter int MAX_CHANNELS = bf3_pkg::DEF_MAX_CHANNELS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [bf3_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bf3_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           req_valid,
	output logic                                req_stall,
	input  wire logic                           req_type,
	input  wire logic [7:0]                     chan0_in,
	input  wire logic [7:0]                     chan1_in,
	input  wire logic [7:0]                     chan2_in,
	output logic                                rsp_valid,
	input  wire logic                           rsp_stall,
	output logic      [7:0]                     chan0_out,
	output logic      [7:0]                     chan1_out,
	output logic      [7:0]                     chan2_out,
	output logic                                frame_last
);
	import bf3_pkg::*;

	localparam int LANES = (MAX_CHANNELS < IO_CHANNELS) ? MAX_CHANNELS : IO_CHANNELS;
	localparam int LW    = 8 * LANES;
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int CMPW  = ((CW > WIDTH_W) ? CW : WIDTH_W) + 1;

	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [CHAN_W-1:0]   chans_q;

	logic [WIDTH_W-1:0]  eff_w;
	logic [HEIGHT_W-1:0] eff_h;
	logic [CHAN_W-1:0]   eff_nc;

	logic adv;
	logic accept;

	logic [CW-1:0]    in_col_q;
	logic [ROW_W-1:0] in_row_q;
	logic [CW-1:0]    out_col_q;
	logic [ROW_W-1:0] out_row_q;

	logic pixel;
	logic in_col_end;
	logic out_col_end;
	logic out_row_end;
	item_ctl_t ctl0;

	logic [IO_CHANNELS-1:0][7:0] chan_in;
	logic [LANES-1:0][7:0]       bot;

	logic                  v_s1;
	logic [CW-1:0]         col_s1;
	logic [LANES-1:0][7:0] bot_s1;
	item_ctl_t             ctl_s1;
	logic                  v_s2;
	item_ctl_t             ctl_s2;
	logic                  v_s3;
	item_ctl_t             ctl_s3;

	logic [2*LW-1:0]       ram_rdata;
	logic [2*LW-1:0]       line_rd;
	logic [2*LW-1:0]       line_wr;
	logic [LANES-1:0][7:0] rd_top;
	logic [LANES-1:0][7:0] rd_mid;
	logic                  fwd_v_q;
	logic [CW-1:0]         fwd_addr_q;
	logic [2*LW-1:0]       fwd_data_q;

	logic [IO_CHANNELS-1:0][7:0] quo;
	logic [IO_CHANNELS-1:0][7:0] out_q;
	logic                        rsp_valid_q;
	logic                        frame_last_q;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_IMAGE_WIDTH;
			height_q <= RST_IMAGE_HEIGHT;
			chans_q  <= RST_CHANNEL_COUNT;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_IMAGE_WIDTH:   width_q  <= cfg_data[WIDTH_W-1:0];
				CFG_IMAGE_HEIGHT:  height_q <= cfg_data[HEIGHT_W-1:0];
				CFG_CHANNEL_COUNT: chans_q  <= cfg_data[CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		eff_w = width_q;
		if (eff_w == '0) eff_w = WIDTH_W'(1);
		if (int'(eff_w) > MAX_WIDTH) eff_w = WIDTH_W'(MAX_WIDTH);
		eff_h = height_q;
		if (eff_h == '0) eff_h = HEIGHT_W'(1);
		eff_nc = chans_q;
		if (eff_nc == '0) eff_nc = CHAN_W'(1);
		if (int'(eff_nc) > LANES) eff_nc = CHAN_W'(LANES);
	end

	// handshake
	assign adv       = !(rsp_valid_q && rsp_stall);
	assign req_stall = !adv;
	assign accept    = req_valid && adv;

	// stage 0: positions, flags, new bottom samples
	assign chan_in = {chan2_in, chan1_in, chan0_in};

	always_comb begin
		pixel       = !req_type && (in_row_q < ROW_W'(eff_h));
		in_col_end  = (CMPW'(in_col_q) + CMPW'(1)) >= CMPW'(eff_w);
		out_col_end = (CMPW'(out_col_q) + CMPW'(1)) >= CMPW'(eff_w);
		out_row_end = (17'(out_row_q) + 17'd1) >= 17'(eff_h);
		ctl0.res       = (in_row_q >= ROW_W'(2)) ||
		                 ((in_row_q == ROW_W'(1)) && (in_col_q != '0));
		ctl0.last      = out_row_end && out_col_end;
		ctl0.rep.top   = (out_row_q == '0);
		ctl0.rep.bot   = out_row_end;
		ctl0.rep.left  = (out_col_q == '0);
		ctl0.rep.right = out_col_end;
		for (int k = 0; k < IO_CHANNELS; k++) begin
			ctl0.mask[k] = (3'(k) < {1'b0, eff_nc});
		end
		for (int k = 0; k < LANES; k++) begin
			bot[k] = (pixel && ctl0.mask[k]) ? chan_in[k] : 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (accept) begin
			if (ctl0.res && ctl0.last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (in_col_end) begin
					in_col_q <= '0;
					if (in_row_q != ROW_LIMIT) in_row_q <= in_row_q + ROW_W'(1);
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
				if (ctl0.res) begin
					if (out_col_end) begin
						out_col_q <= '0;
						if (out_row_q != ROW_LIMIT) out_row_q <= out_row_q + ROW_W'(1);
					end else begin
						out_col_q <= out_col_q + CW'(1);
					end
				end
			end
		end
	end

	// line buffers: {upper, middle} per column
	bf3_ram #(
		.WIDTH(2 * LW),
		.DEPTH(MAX_WIDTH)
	) u_lines (
		.clk  (clk),
		.we   (adv && v_s1),
		.waddr(col_s1),
		.wdata(line_wr),
		.re   (adv),
		.raddr(in_col_q),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			fwd_v_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= accept;
			v_s2    <= v_s1 && ctl_s1.res;
			v_s3    <= v_s2;
			fwd_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			col_s1     <= in_col_q;
			bot_s1     <= bot;
			ctl_s1     <= ctl0;
			ctl_s2     <= ctl_s1;
			ctl_s3     <= ctl_s2;
			fwd_addr_q <= col_s1;
			fwd_data_q <= line_wr;
		end
	end

	// stage 1: bypass the write of the previous transaction
	always_comb begin
		line_rd = (fwd_v_q && (fwd_addr_q == col_s1)) ? fwd_data_q : ram_rdata;
		rd_top  = line_rd[2*LW-1:LW];
		rd_mid  = line_rd[LW-1:0];
		line_wr = {rd_mid, bot_s1};
	end

	// lanes: window, border select, sum, divide
	for (genvar g = 0; g < IO_CHANNELS; g++) begin : g_lane
		if (g < LANES) begin : g_on
			bf3_lane u_lane (
				.clk     (clk),
				.arst_n  (arst_n),
				.shift_en(adv && v_s1),
				.sum_en  (adv),
				.col_top (rd_top[g]),
				.col_mid (rd_mid[g]),
				.col_bot (bot_s1[g]),
				.rep     (ctl_s2.rep),
				.quo     (quo[g])
			);
		end else begin : g_off
			assign quo[g] = 8'd0;
		end
	end

	// merge and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			frame_last_q <= ctl_s3.last;
			for (int k = 0; k < IO_CHANNELS; k++) begin
				out_q[k] <= ctl_s3.mask[k] ? quo[k] : 8'd0;
			end
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign frame_last = frame_last_q;
	assign chan0_out  = out_q[0];
	assign chan1_out  = out_q[1];
	assign chan2_out  = out_q[2];

endmodule

`default_nettype wire
